// ===== design/hgld_pkg.sv =====
// Package for the hashed geometric level draw block.
// Holds hash constants, field widths, register indexes and shared types.
// No dependencies.
package hgld_pkg;

  localparam int HASH_W    = 64;
  localparam int V_W       = 54;
  localparam int M_W       = 9;
  localparam int LEVEL_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int Q_AW      = 2;

  localparam logic [HASH_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [HASH_W-1:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [HASH_W-1:0] MIX_MUL_B    = 64'h94D049BB133111EB;
  localparam logic [V_W-1:0]    UNIT_SCALE   = 54'h20000000000000;

  localparam int SHIFT_A   = 30;
  localparam int SHIFT_B   = 27;
  localparam int SHIFT_C   = 31;
  localparam int SHIFT_TOP = 11;

  localparam logic [M_W-1:0] BRANCH_RESET = 9'd16;
  localparam logic [M_W-1:0] BRANCH_MIN   = 9'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BRANCHING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== design/hgld_mul64lo.sv =====
// Two-stage pipelined 64x64 multiplier returning the low 64 bits of the product.
// Built from three 32x32 partial products; no dependencies.
module hgld_mul64lo (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll_nxt, ll_r;
  logic [31:0] lh_nxt, lh_r;
  logic [31:0] hl_nxt, hl_r;
  logic [31:0] cross_sum;
  logic [63:0] p_r;

  assign ll_nxt    = {32'b0, a[31:0]} * {32'b0, b[31:0]};
  assign lh_nxt    = a[31:0] * b[63:32];
  assign hl_nxt    = a[63:32] * b[31:0];
  assign cross_sum = lh_r + hl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hl_r <= hl_nxt;
      p_r  <= ll_r + {cross_sum, 32'b0};
    end
  end

  assign p = p_r;

endmodule

// ===== design/hgld_fifo.sv =====
// Small synchronous queue with registered pointers and a fill count.
// Depends on hgld_pkg for the status struct.
module hgld_fifo #(
  parameter int W  = 54,
  parameter int AW = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [W-1:0]       wdata,
  input  logic               pop,
  output logic [W-1:0]       rdata,
  output hgld_pkg::q_stat_t  stat
);
  import hgld_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == (AW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue read while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("queue fill count out of range");

endmodule

// ===== design/hgld_front.sv =====
// Front part: accepts item ids, adds the seed product and runs the mixer.
// Depends on hgld_pkg and hgld_mul64lo; emits v = (hash >> 11) + 1.
module hgld_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic signed [hgld_pkg::HASH_W-1:0] in_item_id,
  output logic                          in_full,
  input  logic                          seed_we,
  input  logic [hgld_pkg::HASH_W-1:0]   seed,
  input  logic                          q_ready,
  output logic                          q_valid,
  output logic [hgld_pkg::V_W-1:0]      q_v
);
  import hgld_pkg::*;

  localparam logic [1:0] SEED_LAT = 2'd2;

  logic [HASH_W-1:0] seed_r;
  logic [1:0]        busy_cnt_r;
  logic              busy;
  logic [HASH_W-1:0] seed_gamma;

  logic [4:0]        vld_r;
  logic [HASH_W-1:0] id_r;
  logic              en;
  logic              accept;

  logic [HASH_W-1:0] z0, x1, pa, x2, pb, h;

  // Seed product is refreshed by a free-running multiplier; hold input while it settles.
  hgld_mul64lo u_seed_mul (
    .clk (clk),
    .en  (1'b1),
    .a   (seed_r),
    .b   (GOLDEN_GAMMA),
    .p   (seed_gamma)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= '0;
      busy_cnt_r <= SEED_LAT;
    end else if (seed_we) begin
      seed_r     <= seed;
      busy_cnt_r <= SEED_LAT;
    end else if (busy) begin
      busy_cnt_r <= busy_cnt_r - 1'b1;
    end
  end

  assign busy    = (busy_cnt_r != '0);
  assign en      = !vld_r[4] || q_ready;
  assign in_full = busy || !en;
  assign accept  = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      id_r <= in_item_id;
    end
  end

  assign z0 = id_r + seed_gamma;
  assign x1 = z0 ^ (z0 >> SHIFT_A);

  hgld_mul64lo u_mul_a (
    .clk (clk),
    .en  (en),
    .a   (x1),
    .b   (MIX_MUL_A),
    .p   (pa)
  );

  assign x2 = pa ^ (pa >> SHIFT_B);

  hgld_mul64lo u_mul_b (
    .clk (clk),
    .en  (en),
    .a   (x2),
    .b   (MIX_MUL_B),
    .p   (pb)
  );

  assign h       = pb ^ (pb >> SHIFT_C);
  assign q_v     = {1'b0, h[HASH_W-1:SHIFT_TOP]} + V_W'(1);
  assign q_valid = vld_r[4];

endmodule

// ===== design/hgld_back.sv =====
// Back part: one stage per level, each multiplying the running value by m
// and stopping once it would pass 2^53. Depends on hgld_pkg.
module hgld_back #(
  parameter int LEVEL_CAP = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [hgld_pkg::M_W-1:0]       branching,
  input  logic                           in_valid,
  input  logic [hgld_pkg::V_W-1:0]       in_v,
  output logic                           in_pop,
  input  logic                           out_ready,
  output logic                           out_push,
  output logic [hgld_pkg::LEVEL_W-1:0]   out_level
);
  import hgld_pkg::*;

  localparam int NS = LEVEL_CAP;
  localparam int LW = $clog2(LEVEL_CAP + 1);
  localparam int PW = V_W + M_W;

  logic [NS-1:0]  vld_r;
  logic [V_W-1:0] p_r    [NS];
  logic [LW-1:0]  lvl_r  [NS];
  logic [NS-1:0]  done_r;

  logic [V_W-1:0] p_in   [NS];
  logic [LW-1:0]  lvl_in [NS];
  logic [NS-1:0]  done_in;
  logic           en;

  assign en     = !vld_r[NS-1] || out_ready;
  assign in_pop = in_valid && en;

  // Shift the valid bits one stage deeper, new transaction enters at bit zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= NS'({vld_r, in_valid});
    end
  end

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      logic [PW-1:0] prod;
      logic          step_ok;

      if (k == 0) begin : g_head
        assign p_in[k]    = in_v;
        assign lvl_in[k]  = '0;
        assign done_in[k] = 1'b0;
      end else begin : g_body
        assign p_in[k]    = p_r[k-1];
        assign lvl_in[k]  = lvl_r[k-1];
        assign done_in[k] = done_r[k-1];
      end

      assign prod    = {{M_W{1'b0}}, p_in[k]} * {{V_W{1'b0}}, branching};
      assign step_ok = !done_in[k] && (prod <= {{M_W{1'b0}}, UNIT_SCALE});

      always_ff @(posedge clk) begin
        if (en) begin
          if (step_ok) begin
            p_r[k]   <= prod[V_W-1:0];
            lvl_r[k] <= lvl_in[k] + 1'b1;
          end else begin
            p_r[k]   <= p_in[k];
            lvl_r[k] <= lvl_in[k];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r[k] <= 1'b0;
        end else if (en) begin
          done_r[k] <= !step_ok;
        end
      end
    end
  endgenerate

  assign out_push  = vld_r[NS-1] && out_ready;
  assign out_level = LEVEL_W'(lvl_r[NS-1]);

  a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] |-> (lvl_r[NS-1] <= LW'(LEVEL_CAP)))
    else $error("level above cap");

  a_stop_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NS-1] && (lvl_r[NS-1] != LW'(LEVEL_CAP))) |-> done_r[NS-1])
    else $error("level below cap without a failed step");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NS-1] && !out_ready) |=> (vld_r[NS-1] && $stable(lvl_r[NS-1])))
    else $error("result changed while stalled");

endmodule

// ===== design/hashed_geometric_level_draw_top.sv =====
// Hashed geometric level draw: splitmix64 hash of an item id, then the level.
// Items pass through the front mixer, the middle queue, the back level stages and
//   the result queue. Throughput: one item per cycle; all of them advance every
//   cycle while the result side keeps popping and no hash_seed write settles.
// Reset (rst_n low, synchronous): queues empty, branching 16, hash_seed 0; the
//   input reports full after reset and a hash_seed write while the seed settles.
module hashed_geometric_level_draw_top #(
  parameter int LEVEL_CAP = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [hgld_pkg::HASH_W-1:0]   in_item_id,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [hgld_pkg::LEVEL_W-1:0]         out_level,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hgld_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hgld_pkg::HASH_W-1:0]          cfg_wdata
);
  import hgld_pkg::*;

  logic [M_W-1:0]     branching_r;
  logic               seed_we;

  logic               mid_push, mid_pop;
  logic [V_W-1:0]     mid_wdata, mid_rdata;
  q_stat_t            mid_stat;

  logic               res_push, res_pop;
  logic [LEVEL_W-1:0] res_wdata;
  q_stat_t            res_stat;

  assign cfg_ready = 1'b1;
  assign seed_we   = cfg_valid && (cfg_index == REG_HASH_SEED);

  // Values below two saturate to two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branching_r <= BRANCH_RESET;
    end else if (cfg_valid && (cfg_index == REG_BRANCHING)) begin
      branching_r <= (cfg_wdata[M_W-1:1] == '0) ? BRANCH_MIN : cfg_wdata[M_W-1:0];
    end
  end

  hgld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_item_id (in_item_id),
    .in_full    (in_full),
    .seed_we    (seed_we),
    .seed       (cfg_wdata),
    .q_ready    (!mid_stat.full),
    .q_valid    (mid_push),
    .q_v        (mid_wdata)
  );

  hgld_fifo #(
    .W  (V_W),
    .AW (Q_AW)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push && !mid_stat.full),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .stat  (mid_stat)
  );

  hgld_back #(
    .LEVEL_CAP (LEVEL_CAP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .branching (branching_r),
    .in_valid  (!mid_stat.empty),
    .in_v      (mid_rdata),
    .in_pop    (mid_pop),
    .out_ready (!res_stat.full),
    .out_push  (res_push),
    .out_level (res_wdata)
  );

  assign res_pop = out_pop && !res_stat.empty;

  hgld_fifo #(
    .W  (LEVEL_W),
    .AW (Q_AW)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .pop   (res_pop),
    .rdata (out_level),
    .stat  (res_stat)
  );

  assign out_empty = res_stat.empty;

endmodule

// ===== tb/sv/hashed_geometric_level_draw_top_test.sv =====
// Testbench for hashed_geometric_level_draw_top: drives ids through the queue
// ports, predicts each level with an in-bench hash and level model, checks in order.
// Depends on hgld_pkg and the top level only.
module hashed_geometric_level_draw_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hgld_pkg::*;

  localparam int LEVEL_CAP = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [HASH_W-1:0] UNIT = 64'd1 << 53;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [HASH_W-1:0] in_item_id = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [LEVEL_W-1:0] out_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BRANCHING;
  logic [HASH_W-1:0] cfg_wdata = '0;

  // bench copy of the configuration, updated on each cfg transaction
  logic [M_W-1:0] branching_cfg = BRANCH_RESET;
  logic [HASH_W-1:0] seed_cfg = '0;
  logic [HASH_W-1:0] inv_mul_a, inv_mul_b;

  logic [LEVEL_W-1:0] pending_levels[$];
  int fail_count = 0;
  int cycle_count = 0;
  int pop_hold = 0;
  bit idling = 1'b1;

  hashed_geometric_level_draw_top #(.LEVEL_CAP(LEVEL_CAP)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item_id(in_item_id),
    .out_empty(out_empty), .out_pop(out_pop), .out_level(out_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --- prediction ---------------------------------------------------------

  function automatic logic [HASH_W-1:0] mix_hash(logic [HASH_W-1:0] id,
                                                 logic [HASH_W-1:0] seed);
    logic [HASH_W-1:0] z;
    z = id + seed * GOLDEN_GAMMA;
    z = (z ^ (z >> SHIFT_A)) * MIX_MUL_A;
    z = (z ^ (z >> SHIFT_B)) * MIX_MUL_B;
    return z ^ (z >> SHIFT_C);
  endfunction

  function automatic logic [HASH_W-1:0] eff_branching(logic [M_W-1:0] m);
    return (m < BRANCH_MIN) ? 64'(BRANCH_MIN) : 64'(m);
  endfunction

  // largest L with v * m^L <= 2^53, capped at LEVEL_CAP
  function automatic logic [LEVEL_W-1:0] expected_level(logic [HASH_W-1:0] id,
                                                        logic [M_W-1:0] m_reg,
                                                        logic [HASH_W-1:0] seed);
    logic [HASH_W-1:0] v, m;
    int lvl;
    v = (mix_hash(id, seed) >> SHIFT_TOP) + 64'd1;
    m = eff_branching(m_reg);
    lvl = 0;
    while (lvl < LEVEL_CAP && v * m <= UNIT) begin
      v = v * m;
      lvl++;
    end
    return lvl[LEVEL_W-1:0];
  endfunction

  // --- hash inversion, used to aim ids at chosen draws ---------------------

  function automatic logic [HASH_W-1:0] odd_inverse(logic [HASH_W-1:0] a);
    logic [HASH_W-1:0] x;
    x = a;
    for (int i = 0; i < 5; i++) x = x * (64'd2 - a * x);
    return x;
  endfunction

  function automatic logic [HASH_W-1:0] undo_xorshift(logic [HASH_W-1:0] y, int s);
    logic [HASH_W-1:0] x;
    x = y;
    for (int i = 0; i <= 64 / s; i++) x = y ^ (x >> s);
    return x;
  endfunction

  // id whose draw value v = (hash >> 11) + 1 equals the target
  function automatic logic [HASH_W-1:0] id_for_draw(logic [HASH_W-1:0] v);
    logic [HASH_W-1:0] z;
    z = ((v - 64'd1) << SHIFT_TOP) | 64'($urandom_range(0, 2047));
    z = undo_xorshift(z, SHIFT_C) * inv_mul_b;
    z = undo_xorshift(z, SHIFT_B) * inv_mul_a;
    z = undo_xorshift(z, SHIFT_A);
    return z - seed_cfg * GOLDEN_GAMMA;
  endfunction

  // floor(2^53 / m^L) under the current branching, shifted by delta, clamped
  function automatic logic [HASH_W-1:0] boundary_draw(int lvl, int delta);
    logic [HASH_W-1:0] pw, m, v;
    pw = 64'd1;
    m = eff_branching(branching_cfg);
    for (int i = 0; i < lvl; i++)
      if (pw * m <= UNIT) pw = pw * m;
    v = UNIT / pw;
    if (delta < 0 && v <= 64'(-delta)) return 64'd1;
    v = v + 64'(signed'(delta));
    return (v > UNIT) ? UNIT : v;
  endfunction

  // --- drivers and checker -------------------------------------------------

  task automatic send_item(input logic [HASH_W-1:0] id);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_push = 1'b1;
    in_item_id = id;
    do @(posedge clk); while (in_full);
    pending_levels = {pending_levels, expected_level(id, branching_cfg, seed_cfg)};
    @(negedge clk);
  endtask

  task automatic drain();
    in_push = 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HASH_W-1:0] data);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BRANCHING) branching_cfg = data[M_W-1:0];
    else seed_cfg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (pop_hold > 0) begin
      out_pop = 1'b0;
      pop_hold--;
    end else if (idling && $urandom_range(0, 6) == 0) begin
      out_pop = 1'b0;
      pop_hold = $urandom_range(0, 5);
    end else begin
      out_pop = 1'b1;
    end
  end

  always @(posedge clk) begin : check_levels
    logic [LEVEL_W-1:0] want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_levels.size() == 0) begin
        $error("level: expected none, actual %0d", out_level);
        fail_count++;
      end else begin
        want = pending_levels.pop_front();
        if (out_level !== want) begin
          $error("level: expected %0d, actual %0d", want, out_level);
          fail_count++;
        end
      end
    end
  end

  // --- tests ---------------------------------------------------------------

  task automatic test_reset_defaults();
    send_item(64'd0);
    send_item(64'd1);
    send_item({64{1'b1}});
    send_item(64'h8000000000000000);
    send_item(64'h7FFFFFFFFFFFFFFF);
    send_item(64'hAAAAAAAAAAAAAAAA);
    send_item(id_for_draw(64'd1));   // smallest draw: highest reachable level
    send_item(id_for_draw(UNIT));    // largest draw: level zero
  endtask

  task automatic test_level_boundaries();
    write_reg(REG_BRANCHING, 64'd2);
    send_item(id_for_draw(boundary_draw(LEVEL_CAP, 0)));
    send_item(id_for_draw(boundary_draw(LEVEL_CAP, 1)));
    send_item(id_for_draw(boundary_draw(LEVEL_CAP + 1, 0)));
    // below two saturates to two: exact boundary at one level
    write_reg(REG_BRANCHING, 64'd0);
    send_item(id_for_draw(boundary_draw(1, 0)));
    send_item(id_for_draw(boundary_draw(1, 1)));
    // above the nominal range is used as is
    write_reg(REG_BRANCHING, 64'd511);
    send_item(id_for_draw(boundary_draw(1, 0)));
    send_item(id_for_draw(boundary_draw(1, 1)));
    send_item(id_for_draw(boundary_draw(5, 0)));
  endtask

  task automatic test_seed_mixing();
    write_reg(REG_BRANCHING, 64'd256);
    write_reg(REG_HASH_SEED, {64{1'b1}});
    send_item(64'd0);
    send_item(id_for_draw(boundary_draw(2, 0)));
    write_reg(REG_HASH_SEED, 64'h5555555555555555);
    send_item(64'hFFFFFFFFFFFFFFFF);
    send_item(id_for_draw(boundary_draw(3, 0)));
  endtask

  task automatic test_random_traffic();
    logic [HASH_W-1:0] data;
    for (int phase = 0; phase < 7; phase++) begin
      idling = (phase < 6);
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        data = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          0: data[M_W-1:0] = 9'd0;
          1: data[M_W-1:0] = 9'd1;
          2: data[M_W-1:0] = 9'd2;
          3: data[M_W-1:0] = 9'd256;
          4: data[M_W-1:0] = 9'd257;
          5: data[M_W-1:0] = 9'd511;
          6: data[M_W-1:0] = BRANCH_RESET;
          default: data[M_W-1:0] = 9'($urandom_range(0, 511));
        endcase
        write_reg(REG_BRANCHING, data);
      end
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 3))
          0: data = '0;
          1: data = {64{1'b1}};
          default: data = {$urandom, $urandom};
        endcase
        write_reg(REG_HASH_SEED, data);
      end
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(0, 1) == 0)
          send_item({$urandom, $urandom});
        else
          send_item(id_for_draw(boundary_draw($urandom_range(0, LEVEL_CAP + 1),
                                              $urandom_range(0, 4) - 2)));
      end
    end
  endtask

  initial begin
    inv_mul_a = odd_inverse(MIX_MUL_A);
    inv_mul_b = odd_inverse(MIX_MUL_B);
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_level_boundaries();
    test_seed_mixing();
    test_random_traffic();
    drain();
    // hold for stray results past the pipeline depth
    repeat (LEVEL_CAP + 12) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
